FILE: rtl/agfr_pkg.sv
// Package for the audio gap fade repair block: field widths, mode and register
// codes, default parameter values and the gain unit control word.
// No dependencies.
`timescale 1ns / 1ps

package agfr_pkg;

   localparam int CHANNEL_BITS   = 3;
   localparam int GAP_BITS       = 6;
   localparam int FADE_BITS      = 9;
   localparam int INDEX_BITS     = 8;
   localparam int GAIN_BITS      = 17;
   localparam int RUN_BITS       = 9;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 9;

   localparam int CHANNELS_DEF    = 8;
   localparam int GAP_MAX_DEF     = 63;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int UNITY_GAIN = 65536;

   localparam logic [1:0] CH_MUTED     = 2'd0;
   localparam logic [1:0] CH_LIVE      = 2'd1;
   localparam logic [1:0] CH_RAMP_UP   = 2'd2;
   localparam logic [1:0] CH_RAMP_DOWN = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_LENGTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_LENGTH = 1'd1;

   typedef struct packed {
      logic load;    // capture a new product
      logic invert;  // use one minus the table word
   } gain_ctl_type;

endpackage

FILE: rtl/agfr_gain.sv
// Gain unit: registered sample times Q1.16 gain, floor shift by 16, saturation.
// Depends on agfr_pkg.
`timescale 1ns / 1ps

module agfr_gain #(
   parameter int SAMPLE_BITS = agfr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  agfr_pkg::gain_ctl_type           ctl,
   input  logic signed [SAMPLE_BITS-1:0]    operand,
   input  logic [agfr_pkg::GAIN_BITS-1:0]   gain_word,
   output logic signed [SAMPLE_BITS-1:0]    result
);
   import agfr_pkg::*;

   localparam int GW = GAIN_BITS + 1;
   localparam int PBITS = SAMPLE_BITS + GW;

   logic signed [GW-1:0]          gain_s;
   logic signed [PBITS-1:0]       prod_in;
   logic signed [PBITS-1:0]       prod_ff;
   logic        [SAMPLE_BITS+1:0] q;

   always_comb begin
      if (ctl.invert) begin
         gain_s = $signed(GW'(UNITY_GAIN) - {1'b0, gain_word});
      end else begin
         gain_s = $signed({1'b0, gain_word});
      end
      prod_in = operand * gain_s;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
   end

   // drop 16 fraction bits (floor), then clamp to the sample range
   assign q = prod_ff[PBITS-1:16];

   always_comb begin
      if (q[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000 ||
          q[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111) begin
         result = $signed(q[SAMPLE_BITS-1:0]);
      end else if (q[SAMPLE_BITS+1]) begin
         result = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
      end else begin
         result = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      end
   end

endmodule

FILE: rtl/agfr_line_ram.sv
// Delay line store: one write port, one read port, registered read data.
// Depends on agfr_pkg.
`timescale 1ns / 1ps

module agfr_line_ram #(
   parameter int DEPTH       = agfr_pkg::CHANNELS_DEF * (agfr_pkg::GAP_MAX_DEF + 1),
   parameter int SAMPLE_BITS = agfr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [SAMPLE_BITS-1:0]      wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [SAMPLE_BITS-1:0]      rd_data
);
   import agfr_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/audio_gap_fade_repair.sv
// Top level of the audio gap fade repair block: sequencer, channel state and
// fade table stores. Depends on agfr_pkg, agfr_gain and agfr_line_ram.
//
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_stall | op, channel, sample_in, table_index, table_value
//   rsp_       | out       | rsp_valid/rsp_stall | out_channel, sample_out
//   csr_       | in        | csr_wr_en           | index, wdata
//
// A table word is taken while the sequencer stays idle. A sample passes through
// accept, state read, then table read, multiply, write-back; a gap rewrite
// repeats the last three for each of the gap_length+1 rewritten words.
// After reset a clearing pass zeroes the delay line and channel state, and
// req_stall stays high meanwhile.
// The final write of a sample waits while a previous result is stalled.
`timescale 1ns / 1ps

module audio_gap_fade_repair #(
   parameter int CHANNELS    = agfr_pkg::CHANNELS_DEF,
   parameter int GAP_MAX     = agfr_pkg::GAP_MAX_DEF,
   parameter int TABLE_DEPTH = agfr_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS = agfr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [agfr_pkg::CHANNEL_BITS-1:0]     req_channel,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic [agfr_pkg::INDEX_BITS-1:0]       req_table_index,
   input  logic [agfr_pkg::GAIN_BITS-1:0]        req_table_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [agfr_pkg::CHANNEL_BITS-1:0]     rsp_out_channel,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_wr_en,
   input  logic [agfr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [agfr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import agfr_pkg::*;

   localparam int LINE_LEN  = GAP_MAX + 1;
   localparam int PW        = $clog2(LINE_LEN);
   localparam int DEPTH     = CHANNELS * LINE_LEN;
   localparam int AW        = $clog2(DEPTH);
   localparam int TIW       = $clog2(TABLE_DEPTH);
   localparam int CST_DEPTH = 2 ** CHANNEL_BITS;
   localparam int CLR_LEN   = (DEPTH > CST_DEPTH) ? DEPTH : CST_DEPTH;
   localparam int CLRW      = $clog2(CLR_LEN);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_CST  = 3'd2;
   localparam logic [2:0] S_TRD  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_WR   = 3'd5;

   typedef struct packed {
      logic [1:0]             mode;
      logic [RUN_BITS-1:0]    run;
      logic [SAMPLE_BITS-1:0] last;
      logic [PW-1:0]          ptr;
   } cst_type;

   // position k words behind ptr in a channel's ring, k up to LINE_LEN
   function automatic logic [PW-1:0] ring_index(input logic [PW-1:0] ptr,
                                                input logic [PW:0] k);
      logic [PW:0] t;
      t = (PW+1)'(ptr) + (PW+1)'(LINE_LEN) - k;
      if (t >= (PW+1)'(LINE_LEN)) begin
         t = t - (PW+1)'(LINE_LEN);
      end
      return t[PW-1:0];
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [CLRW-1:0]         clr_ff;
   logic [GAP_BITS-1:0]     gap_ff;
   logic [FADE_BITS-1:0]    fade_ff;
   logic [CHANNEL_BITS-1:0] ch_ff;
   logic [SAMPLE_BITS-1:0]  smp_ff;
   logic [1:0]              mode_ff, mode_in;
   logic [RUN_BITS-1:0]     run_ff, run_in;
   logic [SAMPLE_BITS-1:0]  last_ff, last_in;
   logic [PW-1:0]           ptr_ff;
   logic [PW-1:0]           g_ff, g_in;
   logic [PW-1:0]           k_ff, k_in;
   logic [SAMPLE_BITS-1:0]  plain_ff, plain_in;
   cst_type                 cst_rd_ff;
   logic [GAIN_BITS-1:0]    tbl_rd_ff;
   logic                    rsp_valid_ff;
   logic [CHANNEL_BITS-1:0] rsp_ch_ff;
   logic [SAMPLE_BITS-1:0]  rsp_smp_ff;

   cst_type                 cst_mem [CST_DEPTH];
   logic [GAIN_BITS-1:0]    tbl_mem [TABLE_DEPTH];

   logic                    accept;
   logic                    take_sample;
   logic                    out_free;
   logic                    wr_fire;
   logic                    last_step;
   logic                    scaled;
   logic [RUN_BITS:0]       run_inc;
   logic [1:0]              step_mode;
   logic [RUN_BITS-1:0]     step_run;
   logic [SAMPLE_BITS-1:0]  step_value;
   logic [PW:0]             ptr_inc;
   logic [PW-1:0]           ptr_next;
   logic [AW-1:0]           ch_base;
   logic [TIW-1:0]          tbl_raddr;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [SAMPLE_BITS-1:0]  ram_wr_data;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [SAMPLE_BITS-1:0]  ram_rd_data;
   gain_ctl_type            gain_ctl;
   logic signed [SAMPLE_BITS-1:0] gain_result;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign take_sample = accept && !req_op && (32'(req_channel) < CHANNELS);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign last_step   = (k_ff == '0);
   assign wr_fire     = (state_ff == S_WR) && (!last_step || out_free);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= '0;
         fade_ff <= FADE_BITS'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAP_LENGTH:  gap_ff  <= csr_wdata[GAP_BITS-1:0];
            CSR_FADE_LENGTH: fade_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fade table: written on a table word, read once per step
   always_ff @(posedge clock) begin
      if (accept && req_op && (32'(req_table_index) < TABLE_DEPTH)) begin
         tbl_mem[TIW'(32'(req_table_index))] <= req_table_value;
      end
      if (state_ff == S_TRD) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   assign tbl_raddr = (32'(run_ff) < TABLE_DEPTH) ? TIW'(run_ff) : TIW'(TABLE_DEPTH - 1);

   // channel state store
   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) begin
         if (32'(clr_ff) < CST_DEPTH) begin
            cst_mem[clr_ff[CHANNEL_BITS-1:0]] <= '{mode: CH_MUTED, run: '0, last: '0,
                                                   ptr: '0};
         end
      end else if (wr_fire && last_step) begin
         cst_mem[ch_ff] <= '{mode: step_mode, run: step_run, last: last_ff, ptr: ptr_next};
      end
      if (take_sample) begin
         cst_rd_ff <= cst_mem[req_channel];
      end
   end

   // mode decision on the fresh channel state
   always_comb begin
      logic [RUN_BITS:0] r1;
      logic              zero;
      zero     = (smp_ff == '0);
      g_in     = (32'(gap_ff) > GAP_MAX) ? PW'(GAP_MAX) : PW'(gap_ff);
      mode_in  = cst_rd_ff.mode;
      run_in   = cst_rd_ff.run;
      last_in  = cst_rd_ff.last;
      k_in     = '0;
      plain_in = '0;
      r1       = (RUN_BITS+1)'(cst_rd_ff.run) + 1'b1;
      case (cst_rd_ff.mode)
         CH_MUTED: begin
            if (!zero) begin
               mode_in  = (g_in != '0) ? CH_RAMP_UP : CH_LIVE;
               run_in   = '0;
               plain_in = smp_ff;
            end
         end
         CH_LIVE: begin
            plain_in = smp_ff;
            if (zero && g_in != '0) begin
               if (r1 >= (RUN_BITS+1)'(g_in)) begin
                  // gap found: rewind over the last g words and this one
                  mode_in  = CH_RAMP_DOWN;
                  run_in   = '0;
                  k_in     = g_in;
                  plain_in = '0;
               end else begin
                  run_in = r1[RUN_BITS-1:0];
               end
            end else begin
               run_in  = '0;
               last_in = smp_ff;
            end
         end
         default: ;
      endcase
   end

   // one fade step
   always_comb begin
      scaled     = (mode_ff == CH_RAMP_UP) || (mode_ff == CH_RAMP_DOWN);
      run_inc    = (RUN_BITS+1)'(run_ff) + 1'b1;
      step_mode  = mode_ff;
      step_run   = run_ff;
      step_value = plain_ff;
      if (scaled) begin
         step_value = gain_result;
         if (run_inc >= (RUN_BITS+1)'(fade_ff)) begin
            step_run = '0;
            if (mode_ff == CH_RAMP_UP || g_ff == '0) begin
               step_mode = CH_LIVE;
            end else begin
               step_mode = CH_MUTED;
            end
         end else begin
            step_run = run_inc[RUN_BITS-1:0];
         end
      end
      ptr_inc  = (PW+1)'(ptr_ff) + 1'b1;
      ptr_next = (ptr_inc == (PW+1)'(LINE_LEN)) ? '0 : ptr_inc[PW-1:0];
   end

   assign gain_ctl.load   = (state_ff == S_MUL);
   assign gain_ctl.invert = (mode_ff == CH_RAMP_DOWN);

   agfr_gain #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_gain (
      .clock     (clock),
      .ctl       (gain_ctl),
      .operand   ((mode_ff == CH_RAMP_UP) ? $signed(smp_ff) : $signed(last_ff)),
      .gain_word (tbl_rd_ff),
      .result    (gain_result)
   );

   // delay line ports
   always_comb begin
      ch_base   = AW'(32'(ch_ff) * LINE_LEN);
      ram_rd_en = (state_ff == S_CST);
      ram_rd_addr = AW'(32'(ch_base) +
                        32'(ring_index(cst_rd_ff.ptr, (PW+1)'(g_in) + 1'b1)));
      if (state_ff == S_CLR) begin
         ram_wr_en   = (32'(clr_ff) < DEPTH);
         ram_wr_addr = AW'(32'(clr_ff));
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wr_fire;
         ram_wr_addr = AW'(32'(ch_base) + 32'(ring_index(ptr_ff, (PW+1)'(k_ff))));
         ram_wr_data = step_value;
      end
   end

   agfr_line_ram #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (32'(clr_ff) == CLR_LEN - 1) state_in = S_IDLE;
         S_IDLE: if (take_sample) state_in = S_CST;
         S_CST:  state_in = S_TRD;
         S_TRD:  state_in = S_MUL;
         S_MUL:  state_in = S_WR;
         S_WR: begin
            if (wr_fire) begin
               state_in = last_step ? S_IDLE : S_TRD;
            end
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (wr_fire && last_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         ch_ff  <= req_channel;
         smp_ff <= req_sample_in;
      end
      if (state_ff == S_CST) begin
         mode_ff  <= mode_in;
         run_ff   <= run_in;
         last_ff  <= last_in;
         ptr_ff   <= cst_rd_ff.ptr;
         g_ff     <= g_in;
         k_ff     <= k_in;
         plain_ff <= plain_in;
      end
      if (wr_fire) begin
         mode_ff <= step_mode;
         run_ff  <= step_run;
         if (!last_step) begin
            k_ff <= k_ff - 1'b1;
         end
      end
      if (wr_fire && last_step) begin
         rsp_ch_ff  <= ch_ff;
         rsp_smp_ff <= ram_rd_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_sample_out  = $signed(rsp_smp_ff);

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_WR)
      else $error("word raised without a final write");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> !rsp_valid_ff)
      else $error("word valid during clearing pass");

   a_rewind_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TRD |-> k_ff <= g_ff)
      else $error("rewind reaches beyond the gap length");

   a_rewind_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRD && k_ff != '0) |-> (mode_ff == CH_RAMP_DOWN || mode_ff == CH_MUTED))
      else $error("rewind step outside a fade-out");

endmodule

FILE: sim/audio_gap_fade_repair_tb.sv
// Testbench for audio_gap_fade_repair: random and directed sample and table
// traffic, checked word by word against a scoreboard with its own predictor.
// Depends on agfr_pkg and the audio_gap_fade_repair RTL.
`timescale 1ns / 1ps

class fade_repair_board;
   localparam int LINE_SLOTS = 64;

   int unsigned gap_len;
   int unsigned fade_len;
   logic [1:0] mode [8];
   int unsigned run [8];
   longint held_sample [8];
   longint line [8][LINE_SLOTS];
   int unsigned tap [8];
   longint gain_word [256];
   logic [2:0] want_channel [$];
   logic signed [23:0] want_sample [$];
   int mismatches;

   function new();
      gap_len = 0;
      fade_len = 1;
      mismatches = 0;
      for (int c = 0; c < 8; c++) begin
         mode[c] = agfr_pkg::CH_MUTED;
         run[c] = 0;
         held_sample[c] = 0;
         tap[c] = 0;
         for (int k = 0; k < LINE_SLOTS; k++) line[c][k] = 0;
      end
      for (int i = 0; i < 256; i++) gain_word[i] = 0;
   endfunction

   function void set_reg(logic idx, int unsigned value);
      if (idx == agfr_pkg::CSR_GAP_LENGTH) gap_len = value & 6'h3f;
      else fade_len = value & 9'h1ff;
   endfunction

   function longint scale(longint s, longint gain);
      longint q;
      q = (s * gain) >>> 16;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q;
   endfunction

   function longint table_at(int unsigned pos);
      return gain_word[pos < 256 ? pos : 255];
   endfunction

   function longint fade_in(int c, longint s);
      longint o;
      o = scale(s, table_at(run[c]));
      run[c]++;
      if (run[c] >= fade_len) begin
         mode[c] = agfr_pkg::CH_LIVE;
         run[c] = 0;
      end
      return o;
   endfunction

   function longint fade_out(int c, int unsigned g);
      longint o;
      o = scale(held_sample[c], 64'sd65536 - table_at(run[c]));
      run[c]++;
      if (run[c] >= fade_len) begin
         mode[c] = (g != 0) ? agfr_pkg::CH_MUTED : agfr_pkg::CH_LIVE;
         run[c] = 0;
      end
      return o;
   endfunction

   // Note one accepted input word and, for a sample, queue the sample it pushes out.
   function void note_input(logic op, logic [2:0] ch, logic signed [23:0] smp,
                            logic [7:0] idx, logic [16:0] value);
      int c;
      int unsigned g, p, r;
      longint s, o, v, out_word;
      bit rewind;
      if (op) begin
         gain_word[idx] = value;
         return;
      end
      c = ch;
      s = smp;
      g = gap_len > 63 ? 63 : gap_len;
      p = tap[c];
      out_word = line[c][(p + LINE_SLOTS - (g + 1)) % LINE_SLOTS];
      rewind = 0;
      r = 0;
      o = 0;
      if (mode[c] == agfr_pkg::CH_MUTED) begin
         if (s != 0) begin
            mode[c] = (g != 0) ? agfr_pkg::CH_RAMP_UP : agfr_pkg::CH_LIVE;
            run[c] = 0;
            o = s;
         end
      end else if (mode[c] == agfr_pkg::CH_LIVE) begin
         o = s;
         if (s == 0 && g > 0) begin
            run[c]++;
            if (run[c] >= g) begin
               r = run[c] < g ? run[c] : g;
               mode[c] = agfr_pkg::CH_RAMP_DOWN;
               run[c] = 0;
               rewind = 1;
            end
         end else begin
            run[c] = 0;
            held_sample[c] = s;
         end
      end
      if (rewind) begin
         // rewrite the words still in the line, oldest first, then this one
         for (int k = r; k >= 0; k--) begin
            v = 0;
            if (mode[c] == agfr_pkg::CH_RAMP_DOWN) v = fade_out(c, g);
            line[c][(p + LINE_SLOTS - k) % LINE_SLOTS] = v;
         end
      end else begin
         if (mode[c] == agfr_pkg::CH_RAMP_UP) o = fade_in(c, s);
         else if (mode[c] == agfr_pkg::CH_RAMP_DOWN) o = fade_out(c, g);
         line[c][p] = o;
      end
      tap[c] = (p + 1) % LINE_SLOTS;
      want_channel.push_back(ch);
      want_sample.push_back(out_word[23:0]);
   endfunction

   function void check_result(logic [2:0] ch, logic signed [23:0] smp);
      logic [2:0] ec;
      logic signed [23:0] es;
      if (want_channel.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: channel %0d sample %0d", ch, smp);
         return;
      end
      ec = want_channel.pop_front();
      es = want_sample.pop_front();
      if (ec !== ch || es !== smp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected channel %0d sample %0d, got channel %0d sample %0d",
                     ec, es, ch, smp);
      end
   endfunction

   function int pending();
      return want_channel.size();
   endfunction
endclass

module audio_gap_fade_repair_tb;
   import agfr_pkg::*;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TABLE  = 1'b1;
   localparam int SETTLE_CYCLES = 2 + 3 * 64 + 20;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_op = 0;
   logic [2:0] req_channel = 0;
   logic signed [23:0] req_sample_in = 0;
   logic [7:0] req_table_index = 0;
   logic [16:0] req_table_value = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_out_channel;
   logic signed [23:0] rsp_sample_out;
   logic csr_wr_en = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = 0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = 0;

   fade_repair_board board = new();
   bit steady = 0;

   always #5 clock = ~clock;

   audio_gap_fade_repair dut (.*);

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_input(req_op, req_channel, req_sample_in, req_table_index,
                          req_table_value);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_out_channel, rsp_sample_out);
   end

   // Receiver back-pressure in random bursts; none once steady.
   initial begin
      forever begin
         if (steady) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic op, logic [2:0] ch, logic signed [23:0] smp,
                            logic [7:0] idx, logic [16:0] value);
      if (!steady && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_channel <= ch;
      req_sample_in <= smp;
      req_table_index <= idx;
      req_table_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_sample(logic [2:0] ch, logic signed [23:0] smp);
      send_word(OP_SAMPLE, ch, smp, 8'($urandom), 17'($urandom));
   endtask

   task automatic send_gain(logic [7:0] idx, logic [16:0] value);
      send_word(OP_TABLE, 3'($urandom), 24'($urandom), idx, value);
   endtask

   function automatic logic [16:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic signed [23:0] pick_nonzero();
      logic signed [23:0] v;
      case ($urandom_range(0, 7))
         0: v = 24'sh7fffff;
         1: v = 24'sh800000;
         2: v = 24'sd1;
         3: v = -24'sd1;
         default: v = 24'($urandom);
      endcase
      if (v == 0) v = 24'sd7;
      return v;
   endfunction

   // Drain, settle, then write both registers.
   task automatic reconfigure(int unsigned gap, int unsigned fade);
      req_valid <= 0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= CSR_GAP_LENGTH;
      csr_wdata <= CSR_DATA_BITS'(gap);
      @(posedge clock);
      board.set_reg(CSR_GAP_LENGTH, gap);
      csr_index <= CSR_FADE_LENGTH;
      csr_wdata <= CSR_DATA_BITS'(fade);
      @(posedge clock);
      board.set_reg(CSR_FADE_LENGTH, fade);
      csr_wr_en <= 0;
   endtask

   // Mostly whole bursts on one channel: nonzero words then a zero run
   // around the gap length, so fades in and out get exercised.
   task automatic random_traffic(int n);
      int sent;
      int unsigned g, lo, hi, nz, zeros;
      logic [2:0] ch;
      sent = 0;
      g = board.gap_len;
      while (sent < n) begin
         case ($urandom_range(0, 9))
            0: send_gain(8'($urandom), pick_gain());
            1: begin
               send_sample(3'($urandom), $urandom_range(0, 1) ? pick_nonzero() : 24'sd0);
               sent++;
            end
            default: begin
               ch = 3'($urandom);
               nz = $urandom_range(1, 6);
               lo = g > 1 ? g - 1 : 0;
               hi = g + (board.fade_len > 8 ? 8 : board.fade_len) + 2;
               zeros = g == 0 ? $urandom_range(0, 3) : $urandom_range(lo, hi);
               repeat (nz) send_sample(ch, pick_nonzero());
               repeat (zeros) send_sample(ch, 24'sd0);
               sent += nz + zeros;
            end
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      do @(posedge clock); while (req_stall);
      reconfigure(4, 3);
      for (int i = 0; i < 256; i++) send_gain(8'(i), pick_gain());

      // zero mode, fade-in from extremes, normal, a gap and its fade-out
      send_sample(3'd0, 24'sd0);
      send_sample(3'd0, 24'sh7fffff);
      send_sample(3'd0, 24'sh800000);
      send_sample(3'd0, 24'sd1);
      send_sample(3'd0, -24'sd1);
      send_sample(3'd0, 24'sh555555);
      repeat (4) send_sample(3'd0, 24'sd0);
      repeat (4) send_sample(3'd0, 24'sd0);
      send_sample(3'd0, 24'sh123456);
      send_sample(3'd7, 24'sh800000);
      send_sample(3'd7, 24'sh7fffff);
      send_gain(8'd255, 17'h1ffff);
      send_gain(8'd0, 17'd65536);
      send_sample(3'd7, 24'shaaaaaa);
      repeat (5) send_sample(3'd7, 24'sd0);

      reconfigure(0, 1);
      random_traffic(220);
      reconfigure(1, 1);
      random_traffic(220);
      reconfigure(63, 256);
      random_traffic(260);
      reconfigure(2, 0);
      random_traffic(220);
      reconfigure(5, 511);
      random_traffic(220);
      reconfigure($urandom_range(0, 63), $urandom_range(1, 256));
      random_traffic(240);
      reconfigure(6, 12);
      random_traffic(220);
      reconfigure(3, 8);
      steady = 1;
      random_traffic(220);

      req_valid <= 0;
      for (int n = 0; n < 200000 && board.pending() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() == 0 && board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
